FILE: src/erle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erle_pkg
// Shared types and constants for the escaped run-length run decoder.
// ----------------------------------------------------------------------------
package erle_pkg;

  localparam int SYM_W = 8;
  localparam int LEN_W = 16;

  localparam logic [SYM_W-1:0] ESC_BYTE   = 8'h5C;  // backslash
  localparam logic [SYM_W-1:0] NUL_BYTE   = 8'h00;
  localparam logic [SYM_W-1:0] DIGIT_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] DIGIT_NINE = 8'h39;
  localparam logic [LEN_W-1:0] LEN_MAX    = 16'hFFFF;

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One run descriptor
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
  } run_t;

  // All runs caused by one input byte; the first run is always present
  typedef struct packed {
    run_t first;
    logic has_second;
    run_t second;
  } run_pair_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

FILE: src/erle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erle_front
// Accepts encoded bytes, tracks symbol, count and escape state, and pushes
// the runs that each byte closes into the queue.
// ----------------------------------------------------------------------------
module erle_front import erle_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] in_byte,
  input  logic             stream_end,
  input  queue_status_t    q_status,
  output logic             push,
  output run_pair_t        push_data
);

  localparam int CW    = COUNT_WIDTH;
  localparam int MULW  = CW + 4;
  localparam int WIDEW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  logic [SYM_W-1:0] pending_symbol, pending_symbol_next;
  logic [CW-1:0]    count_value, count_value_next;
  logic             count_seen, count_seen_next;
  logic             escape_pending, escape_pending_next;

  // State after the byte itself, before an end-of-stream flush
  logic [SYM_W-1:0] mid_sym;
  logic [CW-1:0]    mid_cnt;
  logic             mid_seen;
  logic             mid_esc;

  logic             r0_v, r1_v;
  run_t             r0, r1;
  logic             is_digit;
  logic [MULW-1:0]  cnt_x10;
  logic             accept;

  // Length of a flushed run, saturated to the output width
  function automatic logic [LEN_W-1:0] sat_len(input logic [CW-1:0] c);
    logic [WIDEW-1:0] wide;
    wide = WIDEW'(c);
    return (wide > WIDEW'(LEN_MAX)) ? LEN_MAX : wide[LEN_W-1:0];
  endfunction

  // A pending run is emitted unless nothing is pending or its count is zero
  function automatic logic flush_valid(input logic [SYM_W-1:0] s,
                                       input logic [CW-1:0] c,
                                       input logic seen);
    return (s != NUL_BYTE) && !(seen && (c == '0));
  endfunction

  function automatic run_t flush_run(input logic [SYM_W-1:0] s,
                                     input logic [CW-1:0] c,
                                     input logic seen);
    run_t r;
    r.sym = s;
    r.len = seen ? sat_len(c) : LEN_W'(1);
    return r;
  endfunction

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign is_digit = (in_byte >= DIGIT_ZERO) && (in_byte <= DIGIT_NINE);
  // count * 10 + digit, by shift and add
  assign cnt_x10  = (MULW'(count_value) << 3) + (MULW'(count_value) << 1)
                    + MULW'(in_byte - DIGIT_ZERO);

  // Classify the byte
  always_comb begin
    mid_sym  = pending_symbol;
    mid_cnt  = count_value;
    mid_seen = count_seen;
    mid_esc  = escape_pending;
    r0_v     = 1'b0;
    r0       = '{sym: in_byte, len: LEN_W'(1)};
    r1_v     = 1'b0;
    r1       = '{sym: in_byte, len: LEN_W'(1)};
    if (escape_pending) begin
      // escaped byte: literal run of one
      mid_esc = 1'b0;
      r0_v    = 1'b1;
      r0      = '{sym: in_byte, len: LEN_W'(1)};
    end else if (in_byte == ESC_BYTE) begin
      r0_v     = flush_valid(pending_symbol, count_value, count_seen);
      r0       = flush_run(pending_symbol, count_value, count_seen);
      mid_sym  = NUL_BYTE;
      mid_cnt  = '0;
      mid_seen = 1'b0;
      mid_esc  = 1'b1;
    end else if (pending_symbol == NUL_BYTE) begin
      mid_sym  = in_byte;
      mid_cnt  = '0;
      mid_seen = 1'b0;
    end else if (is_digit) begin
      mid_cnt  = (cnt_x10 > MULW'(COUNT_MAX)) ? COUNT_MAX : cnt_x10[CW-1:0];
      mid_seen = 1'b1;
    end else begin
      r0_v     = flush_valid(pending_symbol, count_value, count_seen);
      r0       = flush_run(pending_symbol, count_value, count_seen);
      mid_sym  = in_byte;
      mid_cnt  = '0;
      mid_seen = 1'b0;
    end

    // End of stream flushes and returns to the reset state
    if (stream_end) begin
      r1_v = flush_valid(mid_sym, mid_cnt, mid_seen);
      r1   = flush_run(mid_sym, mid_cnt, mid_seen);
      pending_symbol_next = NUL_BYTE;
      count_value_next    = '0;
      count_seen_next     = 1'b0;
      escape_pending_next = 1'b0;
    end else begin
      pending_symbol_next = mid_sym;
      count_value_next    = mid_cnt;
      count_seen_next     = mid_seen;
      escape_pending_next = mid_esc;
    end
  end

  // Pack the runs so the first slot is always used
  always_comb begin
    push                 = accept && (r0_v || r1_v);
    push_data.first      = r0_v ? r0 : r1;
    push_data.has_second = r0_v && r1_v;
    push_data.second     = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_symbol <= NUL_BYTE;
      count_value    <= '0;
      count_seen     <= 1'b0;
      escape_pending <= 1'b0;
    end else if (accept) begin
      pending_symbol <= pending_symbol_next;
      count_value    <= count_value_next;
      count_seen     <= count_seen_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

FILE: src/erle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erle_queue
// Small register FIFO of run pairs between the front and the back.
// ----------------------------------------------------------------------------
module erle_queue import erle_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  run_pair_t     push_data,
  input  logic          pop,
  output run_pair_t     head,
  output queue_status_t status
);

  run_pair_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign status.full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.valid = (fill != '0);
  assign head         = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: src/erle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erle_back
// Takes run pairs from the queue and sends their runs one per request
// through an output register, marking the last run of each byte.
// ----------------------------------------------------------------------------
module erle_back import erle_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  run_pair_t        head,
  input  queue_status_t    q_status,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_sym,
  output logic [LEN_W-1:0] out_len,
  output logic             out_last
);

  logic sel;   // 1 while the second run of the head entry is next
  logic load;

  assign load = !out_valid || out_ready;
  assign pop  = load && q_status.valid && (sel || !head.has_second);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= q_status.valid;
      if (q_status.valid) begin
        sel <= !sel && head.has_second;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && q_status.valid) begin
      if (sel) begin
        out_sym  <= head.second.sym;
        out_len  <= head.second.len;
        out_last <= 1'b1;
      end else begin
        out_sym  <= head.first.sym;
        out_len  <= head.first.len;
        out_last <= !head.has_second;
      end
    end
  end

endmodule

FILE: src/escaped_rle_run_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_rle_run_decoder
// Decodes an escaped, decimal-count run-length byte stream into run
// descriptors (symbol, length).
// ----------------------------------------------------------------------------
// Accepts one encoded byte per cycle while the queue is not full. The front
// updates symbol, count and escape state in the cycle a byte is taken and
// pushes the runs that byte closes into a 4-entry queue; the back sends one
// run per cycle, when the output is not stalled, through an output register;
// each run passes through a queue entry and then the output register. A byte
// that closes two runs (a new symbol on the final byte) sends them one after
// the other; the queue absorbs these, and input stalls only when the queue
// fills. Run counts are held in COUNT_WIDTH bits and saturate; run_length
// saturates at 65535. m_axis_tlast marks the last run of a byte.
// ----------------------------------------------------------------------------
module escaped_rle_run_decoder import erle_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] run_symbol, [23:8] run_length
  output logic        m_axis_tlast    // last_of_item
);

  queue_status_t    q_status;
  logic             push;
  logic             pop;
  run_pair_t        push_data;
  run_pair_t        head;
  logic [SYM_W-1:0] out_sym;
  logic [LEN_W-1:0] out_len;

  erle_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .stream_end (s_axis_tlast),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  erle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  erle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_sym   (out_sym),
    .out_len   (out_len),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_len, out_sym};

endmodule

FILE: bench/escaped_rle_run_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_rle_run_decoder_tb
// Self-checking bench for the escaped run-length run decoder.
// ----------------------------------------------------------------------------
// Drives encoded bytes on the input stream and compares every run descriptor
// on the output stream against a cycle-free software decoder kept in a small
// scoreboard class. A directed burst covers escapes, zero and saturating
// counts, leading zeros, NUL handling and stream ends; then random
// well-formed tokens mixed with noise run under several idle/stall mixes,
// including one long output hold-off that backs up the block's queue.
// ----------------------------------------------------------------------------
module escaped_rle_run_decoder_tb;
  import erle_pkg::*;

  localparam int          COUNT_W    = 16;
  localparam int unsigned COUNT_MAX  = 32'((64'd1 << COUNT_W) - 1);
  localparam int          CLK_PERIOD = 20;
  localparam int          CYCLE_CAP  = 600000;
  localparam int          PHASE_REQS = 400;
  localparam int          HOLD_LEN   = 300;

  // One expected run descriptor
  typedef struct {
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    logic             last;
  } run_exp_t;

  // Decoder model plus the queue of runs still owed by the block
  class run_scoreboard;
    logic [SYM_W-1:0] sym_q;
    int unsigned      count_q;
    bit               digits_q;
    bit               esc_q;
    run_exp_t         owed[$];
    run_exp_t         step_runs[$];
    int               errors;

    function new();
      sym_q    = NUL_BYTE;
      count_q  = 0;
      digits_q = 0;
      esc_q    = 0;
      errors   = 0;
    endfunction

    function void add_run(logic [SYM_W-1:0] s, int unsigned len);
      run_exp_t r;
      if (len == 0 || step_runs.size() >= 2) return;
      r.sym  = s;
      r.len  = (len > LEN_MAX) ? LEN_MAX : len[LEN_W-1:0];
      r.last = 1'b0;
      step_runs = {step_runs, r};
    endfunction

    // Close the pending run, if any, and clear symbol and count
    function void close_run();
      if (sym_q != NUL_BYTE) add_run(sym_q, digits_q ? count_q : 1);
      sym_q    = NUL_BYTE;
      count_q  = 0;
      digits_q = 0;
    endfunction

    // Accepted input request: update state and queue the runs it closes
    function void note_request(logic [7:0] b, logic stream_end);
      int unsigned d;
      step_runs.delete();
      if (esc_q) begin
        esc_q = 0;
        add_run(b, 1);
      end else if (b == ESC_BYTE) begin
        close_run();
        esc_q = 1;
      end else if (sym_q == NUL_BYTE) begin
        sym_q    = b;
        count_q  = 0;
        digits_q = 0;
      end else if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
        d = 32'(b - DIGIT_ZERO);
        if (count_q > (COUNT_MAX - d) / 10) count_q = COUNT_MAX;
        else count_q = count_q * 10 + d;
        digits_q = 1;
      end else begin
        close_run();
        sym_q = b;
      end
      if (stream_end) begin
        close_run();
        esc_q = 0;
      end
      if (step_runs.size() > 0) step_runs[step_runs.size()-1].last = 1'b1;
      owed = {owed, step_runs};
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    // Accepted output request: compare against the oldest owed run
    function void check_run(logic [23:0] data, logic last);
      run_exp_t r;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected run sym=%02h len=%0d last=%0b",
                       data[7:0], data[23:8], last));
        return;
      end
      r = owed.pop_front();
      if (data[7:0] !== r.sym)
        flag($sformatf("run_symbol exp %02h got %02h", r.sym, data[7:0]));
      if (data[23:8] !== r.len)
        flag($sformatf("run_length exp %0d got %0d (sym %02h)",
                       r.len, data[23:8], r.sym));
      if (last !== r.last)
        flag($sformatf("last_of_item exp %0b got %0b (sym %02h)",
                       r.last, last, r.sym));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  run_scoreboard sb;
  int snd_idle  = 0;
  int rcv_stall = 0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int reqs_sent = 0;
  int cycles    = 0;

  escaped_rle_run_decoder #(.COUNT_WIDTH(COUNT_W)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Monitor both handshakes on the pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_run(m_axis_tdata, m_axis_tlast);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // Offer one byte, with random idle cycles ahead of it, until accepted
  task automatic push_byte(input logic [7:0] b, input logic stream_end);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= stream_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    reqs_sent++;
  endtask

  task automatic push_text(input string s, input bit end_at_last);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], end_at_last && (i == s.len() - 1));
  endtask

  // One random token: mostly symbol + digits, some escapes, NULs and noise
  task automatic push_random_token();
    int          kind;
    int          nd;
    logic [7:0]  sym;
    logic        fin;
    kind = $urandom_range(99);
    fin  = ($urandom_range(11) == 0);
    if (kind < 10) begin
      push_byte(8'($urandom_range(255)), fin);
    end else if (kind < 18) begin
      push_byte(ESC_BYTE, 1'b0);
      push_byte(8'($urandom_range(255)), fin);
    end else if (kind < 22) begin
      push_byte(NUL_BYTE, fin);
    end else begin
      sym = 8'($urandom_range(1, 255));
      while (sym == ESC_BYTE || (sym >= DIGIT_ZERO && sym <= DIGIT_NINE && kind < 95))
        sym = 8'($urandom_range(1, 255));
      nd = ($urandom_range(15) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 3);
      push_byte(sym, fin && nd == 0);
      for (int i = 0; i < nd; i++)
        push_byte(8'(DIGIT_ZERO + $urandom_range(9)), fin && i == nd - 1);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit hold);
    snd_idle  = idle_pct;
    rcv_stall = stall_pct;
    if (hold) hold_req++;
    reqs_sent = 0;
    while (reqs_sent < PHASE_REQS) push_random_token();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: leading zeros, zero count, saturation, NUL handling
    push_text("a007b0c99999", 1'b0);
    push_byte(NUL_BYTE, 1'b0);          // NUL after symbol flushes it
    push_byte(NUL_BYTE, 1'b0);          // NUL with nothing pending is dropped
    push_byte(8'hFF, 1'b0);
    // Escapes: NUL, a digit and a backslash taken literally
    push_byte(ESC_BYTE, 1'b0);
    push_byte(NUL_BYTE, 1'b0);
    push_text("\\5\\\\", 1'b0);
    // Two runs from one final byte, backslash at end, escape on final byte
    push_text("xy", 1'b1);
    push_text("z\\", 1'b1);
    push_text("\\r", 1'b1);
    // A digit with nothing pending becomes the symbol
    push_text("53", 1'b1);

    run_phase(0, 0, 1'b1);
    run_phase(73, 0, 1'b0);
    run_phase(0, 73, 1'b0);
    run_phase(31, 31, 1'b0);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
